// ----- src/mcdda_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-channel DDA pulse scheduler package
// Shared sizes, operation codes and stream packing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mcdda_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int QUEUE_DEPTH  = 16;
  localparam int COUNT_BITS   = 16;

  // Fixed field layout of the stream ports.
  localparam int IN_CHANNELS   = 4;
  localparam int FIELD_BITS    = 16;
  localparam int IN_DATA_BITS  = FIELD_BITS * (1 + IN_CHANNELS);
  localparam int MASK_BITS     = 4;
  localparam int LEVEL_BITS    = 5;
  localparam int OUT_DATA_BITS = 16;
  localparam int OUT_USER_BITS = 2;

  localparam int ERR_BITS = COUNT_BITS + 2;
  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

endpackage

`default_nettype wire

// ----- src/mcdda_channel.sv -----
// ----------------------------------------------------------------------------
// Multi-channel DDA pulse scheduler channel step
// One Bresenham step of one channel, with the error seeded on a period start.
// ----------------------------------------------------------------------------
`default_nettype none

module mcdda_channel (
  input  logic                                  start_i,
  input  logic [mcdda_pkg::COUNT_BITS-1:0]      ticks_i,
  input  logic [mcdda_pkg::COUNT_BITS-1:0]      pulses_i,
  input  logic signed [mcdda_pkg::ERR_BITS-1:0] err_i,
  output logic                                  pulse_o,
  output logic signed [mcdda_pkg::ERR_BITS-1:0] err_o
);
  import mcdda_pkg::*;

  localparam int WideBits = ERR_BITS + 1;

  logic [COUNT_BITS-1:0]      half_ticks;
  logic [COUNT_BITS-1:0]      half_pulses;
  logic signed [ERR_BITS-1:0] seed;
  logic signed [ERR_BITS-1:0] err_cur;
  logic signed [WideBits-1:0] ew;
  logic signed [WideBits-1:0] tw;
  logic signed [WideBits-1:0] dw;
  logic signed [WideBits-1:0] sum;
  logic                       dec;
  logic                       inc;

  // The seed is half of ticks or of minus pulses, truncated toward zero.
  assign half_ticks  = ticks_i >> 1;
  assign half_pulses = pulses_i >> 1;

  always_comb begin
    if (ticks_i > pulses_i) begin
      seed = $signed({{(ERR_BITS-COUNT_BITS){1'b0}}, half_ticks});
    end else begin
      seed = -$signed({{(ERR_BITS-COUNT_BITS){1'b0}}, half_pulses});
    end
  end

  assign err_cur = start_i ? seed : err_i;
  assign ew      = WideBits'(err_cur);
  assign tw      = $signed({{(WideBits-COUNT_BITS){1'b0}}, ticks_i});
  assign dw      = $signed({{(WideBits-COUNT_BITS){1'b0}}, pulses_i});
  assign dec     = ew > -tw;
  assign inc     = ew < dw;
  assign sum     = ew - (dec ? dw : '0) + (inc ? tw : '0);
  assign err_o   = sum[ERR_BITS-1:0];
  assign pulse_o = inc;

endmodule

`default_nettype wire

// ----- src/multi_channel_dda_pulse_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-channel DDA pulse scheduler
// Queues motion periods and steps every channel's Bresenham error per tick.
// ----------------------------------------------------------------------------
// Each input transfer's result is captured in the output register.
// Throughput: one item per cycle while the output register is free or accepted;
// the queue read, error seeding and step of all channels are done between the input and the output register.
// Reset: the queue is empty, no period is active and no result is pending.
// Queue contents are not cleared and need no clearing pass.
`default_nettype none

module multi_channel_dda_pulse_scheduler_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // period_ticks, pulses_ch0, pulses_ch1, pulses_ch2, pulses_ch3
  input  logic [mcdda_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
  // operation
  input  logic                                    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // pulse_mask, queue_level, zero fill
  output logic [mcdda_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
  // period_done
  output logic                                    m_axis_tlast,
  // idle_tick, push_ok
  output logic [mcdda_pkg::OUT_USER_BITS-1:0]     m_axis_tuser
);
  import mcdda_pkg::*;

  logic [COUNT_BITS-1:0] q_ticks  [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0] q_pulses [QUEUE_DEPTH][NUM_CHANNELS];

  logic [PTR_BITS-1:0] head_q, head_d;
  logic [PTR_BITS-1:0] tail_q, tail_d;
  logic [PTR_BITS-1:0] tail_inc;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                active_q, active_d;
  logic [COUNT_BITS-1:0] act_ticks_q, act_ticks_d;
  logic [COUNT_BITS-1:0] act_pulses_q [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] act_pulses_d [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] tick_idx_q, tick_idx_d;
  logic signed [ERR_BITS-1:0] err_q [NUM_CHANNELS];
  logic signed [ERR_BITS-1:0] err_d [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pulse;

  logic                  in_fire;
  logic                  is_push;
  logic                  can_push;
  logic                  do_store;
  logic                  start;
  logic                  run;
  logic [COUNT_BITS-1:0] idx_inc;
  logic                  done;
  logic [MASK_BITS-1:0]  mask;
  logic [COUNT_BITS-1:0] in_ticks;
  logic [COUNT_BITS-1:0] in_pulses [NUM_CHANNELS];

  logic                     m_valid_q;
  logic [MASK_BITS-1:0]     mask_q;
  logic                     done_q;
  logic                     idle_q;
  logic                     ok_q;
  logic [LEVEL_BITS-1:0]    level_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_push       = s_axis_tuser == OP_PUSH;
  assign can_push      = count_q != CNT_BITS'(QUEUE_DEPTH);
  assign do_store      = is_push && can_push;
  assign start         = !is_push && !active_q && (count_q != '0);
  assign run           = !is_push && (active_q || start);
  assign tail_inc      = (tail_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  always_comb begin
    in_ticks = COUNT_BITS'(s_axis_tdata[FIELD_BITS-1:0]);
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (c < IN_CHANNELS) begin
        in_pulses[c] = COUNT_BITS'(s_axis_tdata[FIELD_BITS*(c+1) +: FIELD_BITS]);
      end else begin
        in_pulses[c] = '0;
      end
    end
  end

  always_comb begin
    act_ticks_d = start ? q_ticks[head_q] : act_ticks_q;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      act_pulses_d[c] = start ? q_pulses[head_q][c] : act_pulses_q[c];
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : gen_ch
    mcdda_channel u_channel (
      .start_i  (start),
      .ticks_i  (act_ticks_d),
      .pulses_i (act_pulses_d[g]),
      .err_i    (err_q[g]),
      .pulse_o  (pulse[g]),
      .err_o    (err_d[g])
    );
  end

  assign idx_inc = (start ? '0 : tick_idx_q) + 1'b1;
  assign done    = run && (idx_inc >= act_ticks_d);

  always_comb begin
    mask = '0;
    for (int c = 0; c < MASK_BITS; c++) begin
      if (c < NUM_CHANNELS) begin
        mask[c] = run && pulse[c];
      end
    end
  end

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    active_d   = active_q;
    tick_idx_d = tick_idx_q;
    if (do_store) begin
      tail_d  = tail_inc;
      count_d = count_q + 1'b1;
    end
    if (start) begin
      head_d  = (head_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (run) begin
      tick_idx_d = idx_inc;
      active_d   = !done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && do_store) begin
      q_ticks[tail_inc] <= in_ticks;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        q_pulses[tail_inc][c] <= in_pulses[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && run) begin
      act_ticks_q <= act_ticks_d;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        act_pulses_q[c] <= act_pulses_d[c];
        err_q[c]        <= err_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= PTR_BITS'(QUEUE_DEPTH - 1);
      count_q    <= '0;
      active_q   <= 1'b0;
      tick_idx_q <= '0;
    end else if (in_fire) begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      active_q   <= active_d;
      tick_idx_q <= tick_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mask_q  <= mask;
      done_q  <= done;
      idle_q  <= !is_push && !run;
      ok_q    <= do_store;
      level_q <= LEVEL_BITS'(count_d);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'({level_q, mask_q});
  assign m_axis_tlast  = done_q;
  assign m_axis_tuser  = {ok_q, idle_q};

endmodule

`default_nettype wire
